@@ hw/rtl/sis_pkg.sv @@
// Shared types and constants for the sorted identifier set.
package sis_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned ID_WIDTH_DEF  = 32;

  localparam int unsigned FUNC_W        = 2;
  localparam int unsigned SCOPE_ID_W    = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // func + scope_id = 34 bits, padded to whole bytes
  localparam int unsigned IN_TDATA_W    = 40;
  // ok + was_present + status + entry_count = 9 bits, padded
  localparam int unsigned OUT_TDATA_W   = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD      = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_FLIP     = 2'd2,
    FUNC_CONTAINS = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  // Broadcast control to every cell of the chain.
  typedef struct packed {
    logic cmp;  // latch compare flags against the key
    logic ins;  // insert key at first slot not below it
    logic del;  // close the gap at the matching slot
  } sis_ctrl_t;

endpackage

@@ hw/rtl/sorted_id_set.sv @@
// Top level of the sorted identifier set: control, chain of cells, result register.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+------------------------------------------
//  s_axis  | in  | s_axis_tvalid_i/s_axis_tready_o | tdata: func[1:0], scope_id[33:2]
//  m_axis  | out | m_axis_tvalid_o/m_axis_tready_i | tdata: ok[0], was_present[1],
//          |     |                               |        status[3:2], entry_count[8:4]
//
// Each transaction passes through accept, compare (every cell checks its entry
// against the key in parallel) and apply (cells shift toward or away from their neighbor).
// The result lands in an output register, so the next transaction is accepted while
// a finished result is still waiting on m_axis_tready_i.
// The apply step stalls while the output register holds an untaken result.
// Reset clears the valid bits and the entry count; entry data is not reset.
module sorted_id_set import sis_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // func[1:0], scope_id[33:2], zero pad
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // ok, was_present, status[1:0],
                                                   // entry_count[4:0], zero pad
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e              state_q, state_d;
  func_e               func_q;
  logic [ID_WIDTH-1:0] key_q, key_in;
  logic [CNT_W-1:0]    held_q, held_d;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  sis_ctrl_t ctrl;

  logic [ID_WIDTH-1:0] entry_vec [CAPACITY];
  logic [CAPACITY-1:0] valid_vec, lt_vec, eq_vec;

  logic s_accept, out_free;
  logic hit, full, do_add, do_rem, do_ins, do_del, ok;
  status_e status;
  logic [ENTRY_COUNT_W-1:0] count_out;

  // identifier taken in its low ID_WIDTH bits, zero-extended when ID_WIDTH exceeds 32
  if (ID_WIDTH >= SCOPE_ID_W) begin : g_key_wide
    assign key_in = ID_WIDTH'(s_axis_tdata_i[FUNC_W +: SCOPE_ID_W]);
  end else begin : g_key_narrow
    assign key_in = s_axis_tdata_i[FUNC_W +: ID_WIDTH];
  end

  // count reported modulo 32
  if (CNT_W >= ENTRY_COUNT_W) begin : g_cnt_wide
    assign count_out = held_d[ENTRY_COUNT_W-1:0];
  end else begin : g_cnt_narrow
    assign count_out = ENTRY_COUNT_W'(held_d);
  end

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign hit  = |eq_vec;
  assign full = (held_q == CNT_W'(CAPACITY));

  // FSM and result decode
  always_comb begin
    state_d     = state_q;
    ctrl        = '0;
    do_add      = 1'b0;
    do_rem      = 1'b0;
    ok          = 1'b0;
    status      = ST_DONE;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;

    case (func_q)
      FUNC_ADD:    do_add = 1'b1;
      FUNC_REMOVE: do_rem = 1'b1;
      FUNC_FLIP: begin
        do_add = !hit;
        do_rem = hit;
      end
      default: ;
    endcase

    if (do_add) begin
      ok = hit || !full;
      if (!hit && full) status = ST_FULL;
    end else if (do_rem) begin
      ok = hit;
      if (!hit) status = ST_NOT_FOUND;
    end else begin
      ok = hit;
    end

    do_ins = 1'b0;
    do_del = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_accept) state_d = S_CMP;
      end
      S_CMP: begin
        ctrl.cmp = 1'b1;
        state_d  = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) begin
          do_ins      = do_add && !hit && !full;
          do_del      = do_rem && hit;
          ctrl.ins    = do_ins;
          ctrl.del    = do_del;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    held_d = held_q;
    if (do_ins) held_d = held_q + CNT_W'(1);
    if (do_del) held_d = held_q - CNT_W'(1);

    if (state_q == S_APPLY && out_free) begin
      out_data_d = OUT_TDATA_W'({count_out, status, hit, ok});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q <= func_e'(s_axis_tdata_i[FUNC_W-1:0]);
      key_q  <= key_in;
    end
    out_data_q <= out_data_d;
  end

  // chain of cells; each hands its entry to each of its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_WIDTH-1:0] prev_entry, next_entry;
    logic                prev_valid, prev_lt, next_valid;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_valid = 1'b0;
      assign prev_lt    = 1'b1;
    end else begin : g_body
      assign prev_entry = entry_vec[i-1];
      assign prev_valid = valid_vec[i-1];
      assign prev_lt    = lt_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_entry = entry_vec[i+1];
      assign next_valid = valid_vec[i+1];
    end

    sis_cell #(
      .ID_WIDTH(ID_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .key_i        (key_q),
      .prev_entry_i (prev_entry),
      .prev_valid_i (prev_valid),
      .prev_lt_i    (prev_lt),
      .next_entry_i (next_entry),
      .next_valid_i (next_valid),
      .entry_o      (entry_vec[i]),
      .valid_o      (valid_vec[i]),
      .lt_o         (lt_vec[i]),
      .eq_o         (eq_vec[i])
    );
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

@@ hw/rtl/sis_cell.sv @@
// One slot of the sorted chain: entry, valid bit and compare flags.
module sis_cell import sis_pkg::*; #(
  parameter int unsigned ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sis_ctrl_t           ctrl_i,
  input  logic [ID_WIDTH-1:0] key_i,
  input  logic [ID_WIDTH-1:0] prev_entry_i,
  input  logic                prev_valid_i,
  input  logic                prev_lt_i,
  input  logic [ID_WIDTH-1:0] next_entry_i,
  input  logic                next_valid_i,
  output logic [ID_WIDTH-1:0] entry_o,
  output logic                valid_o,
  output logic                lt_o,
  output logic                eq_o
);

  logic [ID_WIDTH-1:0] entry_q, entry_d;
  logic                valid_q, valid_d;
  logic                lt_q, lt_d;
  logic                eq_q, eq_d;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    lt_d    = lt_q;
    eq_d    = eq_q;
    if (ctrl_i.cmp) begin
      lt_d = valid_q && (entry_q < key_i);
      eq_d = valid_q && (entry_q == key_i);
    end
    // slots below the key never move
    if (ctrl_i.ins && !lt_q) begin
      if (prev_lt_i) begin
        entry_d = key_i;
        valid_d = 1'b1;
      end else begin
        entry_d = prev_entry_i;
        valid_d = prev_valid_i;
      end
    end
    if (ctrl_i.del && !lt_q) begin
      entry_d = next_entry_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign valid_o = valid_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule
